>>> hw/rtl/lcm_pkg.sv
// Shared types and constants for the letterbox coordinate mapper.
`default_nettype none
package lcm_pkg;

    localparam int DIV_STEPS = 27;

    typedef logic        action_t;
    typedef logic signed [13:0] coord_t;
    typedef logic signed [15:0] mapped_t;
    typedef logic [11:0] edge_t;
    typedef logic [12:0] dim_t;

    typedef enum logic [1:0] {
        REG_FB_WIDTH   = 2'd0,
        REG_FB_HEIGHT  = 2'd1,
        REG_WIN_WIDTH  = 2'd2,
        REG_WIN_HEIGHT = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        PJ_IDLE,
        PJ_XS,
        PJ_YS,
        PJ_WH,
        PJ_HW,
        PJ_FIN
    } proj_state_t;

    // one axis in flight through the pipelined divider
    typedef struct packed {
        logic [12:0] rem;
        logic [26:0] wk;
        logic [12:0] den;
        logic        neg;
        logic [11:0] add;
    } div_lane_t;

endpackage
`default_nettype wire

>>> hw/rtl/lcm_in_if.sv
// Input channel: one coordinate word with its direction.
`default_nettype none
interface lcm_in_if;
    import lcm_pkg::*;
    logic    valid;
    logic    ready;
    action_t action;
    coord_t  in_x;
    coord_t  in_y;
    modport source (output valid, output action, output in_x, output in_y, input ready);
    modport sink (input valid, input action, input in_x, input in_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lcm_out_if.sv
// Output channel: mapped point, output area and error flag.
`default_nettype none
interface lcm_out_if;
    import lcm_pkg::*;
    logic    valid;
    logic    ready;
    mapped_t out_x;
    mapped_t out_y;
    edge_t   area_x;
    edge_t   area_y;
    dim_t    area_w;
    dim_t    area_h;
    logic    error;
    modport source (output valid, output out_x, output out_y, output area_x,
                     output area_y, output area_w, output area_h, output error,
                     input ready);
    modport sink (input valid, input out_x, input out_y, input area_x,
                  input area_y, input area_w, input area_h, input error,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/letterbox_coordinate_mapper_top.sv
// Letterbox coordinate mapper: projection unit and pipelined point mapper.
//
// Usage:
//  - cfg_we/cfg_index/cfg_data write framebuffer and window sizes
//    (index 0..3: fb width, fb height, win width, win height). Window
//    writes outside 1..MAX_DIM are dropped. Write only while idle.
//  - After reset and after every accepted write, a serial divider rebuilds
//    the output area: four 26-bit divisions, then a final step places the
//    area. coord.ready stays low meanwhile.
//  - coord carries one point word (action, in_x, in_y); action 0 maps
//    framebuffer to window, 1 maps window to framebuffer.
//  - result carries the mapped point, the area and the error flag.
//  - From acceptance to result.valid a word passes the registers multiply,
//    magnitude, 27 one-bit divider stages, sign/offset, saturate/output.
//  - Throughput is one word per cycle unless result stalls or the area is
//    rebuilt; the 27-stage restoring divider per axis is the long path.
//  - When result stalls, the whole pipeline holds; valid bits move with
//    the data, so nothing is dropped or repeated.
`default_nettype none
module letterbox_coordinate_mapper_top #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lcm_in_if.sink           coord,
    lcm_out_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    import lcm_pkg::*;

    // ---------------- configuration registers ----------------
    logic [12:0] fw_reg, fh_reg, ww_reg, wh_reg;
    logic        win_ok;
    logic        cfg_hit;

    assign win_ok = (cfg_data != 13'd0) && (32'(cfg_data) <= 32'(MAX_DIM));

    always_comb
    begin
        unique case (reg_index_t'(cfg_index))
            REG_FB_WIDTH, REG_FB_HEIGHT:   cfg_hit = cfg_we;
            REG_WIN_WIDTH, REG_WIN_HEIGHT: cfg_hit = cfg_we && win_ok;
            default:                       cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 13'd1;
            fh_reg <= 13'd1;
            ww_reg <= 13'd1;
            wh_reg <= 13'd1;
        end
        else if (cfg_hit)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FB_WIDTH:   fw_reg <= cfg_data;
                REG_FB_HEIGHT:  fh_reg <= cfg_data;
                REG_WIN_WIDTH:  ww_reg <= cfg_data;
                REG_WIN_HEIGHT: wh_reg <= cfg_data;
                default:        fw_reg <= fw_reg;
            endcase
        end
    end

    // ---------------- projection unit ----------------
    // One shared restoring divider, one quotient bit per cycle.
    proj_state_t pj_state_reg, pj_state_next;
    logic [4:0]  pj_cnt_reg, pj_cnt_next;
    logic [12:0] pj_rem_reg, pj_rem_next;
    logic [25:0] pj_wk_reg, pj_wk_next;
    logic [12:0] xs_reg, xs_next, ys_reg, ys_next;
    logic [25:0] wforh_reg, wforh_next, hforw_reg, hforw_next;
    logic [11:0] al_reg, al_next, at_reg, at_next;
    logic [12:0] aw_reg, aw_next, ah_reg, ah_next;

    logic [25:0] pj_dvd;
    logic [12:0] pj_dvs;
    logic [13:0] pj_sh;
    logic        pj_ge;
    logic [12:0] pj_s;
    logic [14:0] pj_wint, pj_hint;
    logic [12:0] pj_w, pj_h;

    always_comb
    begin
        unique case (pj_state_reg)
            PJ_XS:   begin pj_dvd = {13'd0, ww_reg}; pj_dvs = fw_reg; end
            PJ_YS:   begin pj_dvd = {13'd0, wh_reg}; pj_dvs = fh_reg; end
            PJ_WH:   begin pj_dvd = fw_reg * wh_reg; pj_dvs = fh_reg; end
            PJ_HW:   begin pj_dvd = fh_reg * ww_reg; pj_dvs = fw_reg; end
            default: begin pj_dvd = 26'd0;           pj_dvs = 13'd1;  end
        endcase
    end

    assign pj_sh = {pj_rem_reg, pj_wk_reg[25]};
    assign pj_ge = pj_sh >= {1'b0, pj_dvs};

    // area placement from the four quotients
    assign pj_s    = (xs_reg < ys_reg) ? xs_reg : ys_reg;
    assign pj_wint = fw_reg * pj_s[1:0];
    assign pj_hint = fh_reg * pj_s[1:0];

    always_comb
    begin
        if (fw_reg == 13'd0 || fh_reg == 13'd0)
        begin
            pj_w = 13'd0;
            pj_h = 13'd0;
        end
        else if (pj_s != 13'd0 && pj_s < 13'd4)
        begin
            pj_w = pj_wint[12:0];
            pj_h = pj_hint[12:0];
        end
        else if (wforh_reg <= {13'd0, ww_reg})
        begin
            pj_w = wforh_reg[12:0];
            pj_h = wh_reg;
        end
        else
        begin
            pj_w = ww_reg;
            pj_h = hforw_reg[12:0];
        end
    end

    always_comb
    begin
        pj_state_next = pj_state_reg;
        pj_cnt_next   = pj_cnt_reg;
        pj_rem_next   = pj_rem_reg;
        pj_wk_next    = pj_wk_reg;
        xs_next       = xs_reg;
        ys_next       = ys_reg;
        wforh_next    = wforh_reg;
        hforw_next    = hforw_reg;
        al_next       = al_reg;
        at_next       = at_reg;
        aw_next       = aw_reg;
        ah_next       = ah_reg;
        if (cfg_hit)
        begin
            pj_state_next = PJ_XS;
            pj_cnt_next   = 5'd0;
        end
        else
        begin
            unique case (pj_state_reg)
                PJ_IDLE: ;
                PJ_XS, PJ_YS, PJ_WH, PJ_HW:
                begin
                    if (pj_cnt_reg == 5'd0)
                    begin
                        pj_rem_next = 13'd0;
                        pj_wk_next  = pj_dvd;
                        pj_cnt_next = pj_cnt_reg + 5'd1;
                    end
                    else if (pj_cnt_reg <= 5'd26)
                    begin
                        pj_rem_next = pj_ge ? 13'(pj_sh - {1'b0, pj_dvs}) : pj_sh[12:0];
                        pj_wk_next  = {pj_wk_reg[24:0], pj_ge};
                        pj_cnt_next = pj_cnt_reg + 5'd1;
                    end
                    else
                    begin
                        pj_cnt_next = 5'd0;
                        unique case (pj_state_reg)
                            PJ_XS:
                            begin
                                xs_next       = pj_wk_reg[12:0];
                                pj_state_next = PJ_YS;
                            end
                            PJ_YS:
                            begin
                                ys_next       = pj_wk_reg[12:0];
                                pj_state_next = PJ_WH;
                            end
                            PJ_WH:
                            begin
                                wforh_next    = pj_wk_reg;
                                pj_state_next = PJ_HW;
                            end
                            default:
                            begin
                                hforw_next    = pj_wk_reg;
                                pj_state_next = PJ_FIN;
                            end
                        endcase
                    end
                end
                PJ_FIN:
                begin
                    aw_next       = pj_w;
                    ah_next       = pj_h;
                    al_next       = ww_reg[12:1] - pj_w[12:1];
                    at_next       = wh_reg[12:1] - pj_h[12:1];
                    pj_state_next = PJ_IDLE;
                end
                default: pj_state_next = PJ_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pj_state_reg <= PJ_XS;
            pj_cnt_reg   <= 5'd0;
            al_reg       <= 12'd0;
            at_reg       <= 12'd0;
            aw_reg       <= 13'd0;
            ah_reg       <= 13'd0;
        end
        else
        begin
            pj_state_reg <= pj_state_next;
            pj_cnt_reg   <= pj_cnt_next;
            al_reg       <= al_next;
            at_reg       <= at_next;
            aw_reg       <= aw_next;
            ah_reg       <= ah_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pj_rem_reg <= pj_rem_next;
        pj_wk_reg  <= pj_wk_next;
        xs_reg     <= xs_next;
        ys_reg     <= ys_next;
        wforh_reg  <= wforh_next;
        hforw_reg  <= hforw_next;
    end

    // ---------------- point pipeline ----------------
    logic pipe_en;
    logic in_acc;
    logic out_v_reg;

    assign pipe_en     = !out_v_reg || result.ready;
    assign coord.ready = pipe_en && (pj_state_reg == PJ_IDLE);
    assign in_acc      = coord.valid && coord.ready;

    // stage 1: one signed multiply per axis
    logic signed [14:0] ax, ay;
    logic signed [13:0] bx, by;
    logic signed [28:0] nx, ny;
    logic               s1_v_reg;
    logic signed [28:0] s1_nx_reg, s1_ny_reg;
    logic [12:0]        s1_dx_reg, s1_dy_reg;
    logic [11:0]        s1_ax_reg, s1_ay_reg;

    assign ax = coord.action ? ($signed({coord.in_x[13], coord.in_x}) - $signed({3'b0, al_reg}))
                             : $signed({coord.in_x[13], coord.in_x});
    assign ay = coord.action ? ($signed({coord.in_y[13], coord.in_y}) - $signed({3'b0, at_reg}))
                             : $signed({coord.in_y[13], coord.in_y});
    assign bx = coord.action ? $signed({1'b0, fw_reg}) : $signed({1'b0, aw_reg});
    assign by = coord.action ? $signed({1'b0, fh_reg}) : $signed({1'b0, ah_reg});
    assign nx = ax * bx;
    assign ny = ay * by;

    // stage 2 input: magnitude and sign into divider lane 0
    div_lane_t lx0, ly0;
    logic [28:0] mx, my;

    assign mx = s1_nx_reg[28] ? 29'(-s1_nx_reg) : 29'(s1_nx_reg);
    assign my = s1_ny_reg[28] ? 29'(-s1_ny_reg) : 29'(s1_ny_reg);

    always_comb
    begin
        lx0.rem = 13'd0;
        lx0.wk  = mx[26:0];
        lx0.den = s1_dx_reg;
        lx0.neg = s1_nx_reg[28];
        lx0.add = s1_ax_reg;
        ly0.rem = 13'd0;
        ly0.wk  = my[26:0];
        ly0.den = s1_dy_reg;
        ly0.neg = s1_ny_reg[28];
        ly0.add = s1_ay_reg;
    end

    function automatic div_lane_t div_step(input div_lane_t l);
        div_lane_t   r;
        logic [13:0] sh;
        logic        ge;
        sh    = {l.rem, l.wk[26]};
        ge    = sh >= {1'b0, l.den};
        r     = l;
        r.rem = ge ? 13'(sh - {1'b0, l.den}) : sh[12:0];
        r.wk  = {l.wk[25:0], ge};
        return r;
    endfunction

    // lane[0] holds the magnitude; lane[k] holds k quotient bits
    div_lane_t lx_reg [DIV_STEPS+1];
    div_lane_t ly_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            dv_reg   <= '0;
        end
        else if (pipe_en)
        begin
            s1_v_reg <= in_acc;
            dv_reg   <= {dv_reg[DIV_STEPS-1:0], s1_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_nx_reg <= nx;
            s1_ny_reg <= ny;
            s1_dx_reg <= coord.action ? aw_reg : fw_reg;
            s1_dy_reg <= coord.action ? ah_reg : fh_reg;
            s1_ax_reg <= coord.action ? 12'd0 : al_reg;
            s1_ay_reg <= coord.action ? 12'd0 : at_reg;
            lx_reg[0] <= lx0;
            ly_reg[0] <= ly0;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                lx_reg[k] <= div_step(lx_reg[k-1]);
                ly_reg[k] <= div_step(ly_reg[k-1]);
            end
        end
    end

    // sign and offset
    div_lane_t          lxq, lyq;
    logic signed [28:0] qx, qy;
    logic signed [28:0] rx_next, ry_next;
    logic               fin_v_reg;
    logic signed [28:0] rx_reg, ry_reg;
    logic               zx_reg, zy_reg, negx_reg, negy_reg;

    assign lxq = lx_reg[DIV_STEPS];
    assign lyq = ly_reg[DIV_STEPS];
    assign qx  = lxq.neg ? -$signed({2'b0, lxq.wk}) : $signed({2'b0, lxq.wk});
    assign qy  = lyq.neg ? -$signed({2'b0, lyq.wk}) : $signed({2'b0, lyq.wk});
    assign rx_next = qx + $signed({17'd0, lxq.add});
    assign ry_next = qy + $signed({17'd0, lyq.add});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            fin_v_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            zx_reg   <= (lxq.den == 13'd0);
            zy_reg   <= (lyq.den == 13'd0);
            negx_reg <= lxq.neg;
            negy_reg <= lyq.neg;
        end
    end

    // saturation into the output register
    localparam logic signed [28:0] SAT_HI = 29'sd32767;
    localparam logic signed [28:0] SAT_LO = -29'sd32768;

    mapped_t sx, sy;
    logic    ex, ey;

    always_comb
    begin
        ex = 1'b1;
        ey = 1'b1;
        if (zx_reg)
            sx = negx_reg ? 16'sh8000 : 16'sh7FFF;
        else if (rx_reg > SAT_HI)
            sx = 16'sh7FFF;
        else if (rx_reg < SAT_LO)
            sx = 16'sh8000;
        else
        begin
            sx = rx_reg[15:0];
            ex = 1'b0;
        end
        if (zy_reg)
            sy = negy_reg ? 16'sh8000 : 16'sh7FFF;
        else if (ry_reg > SAT_HI)
            sy = 16'sh7FFF;
        else if (ry_reg < SAT_LO)
            sy = 16'sh8000;
        else
        begin
            sy = ry_reg[15:0];
            ey = 1'b0;
        end
    end

    mapped_t out_x_reg, out_y_reg;
    logic    err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_v_reg <= fin_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_x_reg <= sx;
            out_y_reg <= sy;
            err_reg   <= ex || ey;
        end
    end

    // area is stable while words are in flight as long as writes come only while idle; the block does not enforce that
    assign result.valid  = out_v_reg;
    assign result.out_x  = out_x_reg;
    assign result.out_y  = out_y_reg;
    assign result.area_x = al_reg;
    assign result.area_y = at_reg;
    assign result.area_w = aw_reg;
    assign result.area_h = ah_reg;
    assign result.error  = err_reg;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the letterbox coordinate mapper.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import lcm_pkg::*;

    // Settle time after the last result: the pipeline is 31 deep.
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 100;
    localparam int IDLE_PCT     = 21;

    typedef struct {
        mapped_t ox;
        mapped_t oy;
        edge_t   ax;
        edge_t   ay;
        dim_t    aw;
        dim_t    ah;
        logic    err;
    } mapped_word_t;

    // One row of the directed table: either a register write or a point word.
    // Rows with a typed answer are checked against it instead of the predictor.
    typedef struct {
        bit           is_cfg;
        reg_index_t   idx;
        int           data;
        action_t      act;
        int           x;
        int           y;
        bit           typed;
        mapped_word_t ans;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    lcm_in_if  coord ();
    lcm_out_if result ();

    letterbox_coordinate_mapper_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .coord     (coord.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the registers and the projection.
    int    fb_w, fb_h, win_w, win_h;
    bit    area_stale;
    edge_t area_l, area_t;
    dim_t  area_wd, area_ht;

    mapped_word_t pending_words[$];
    int  mismatches;
    int  words_sent;
    int  words_seen;
    int  sat_seen;
    bit  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report(string what, longint got, longint want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Register write as the block takes it: fb sizes stored as is, window
    // sizes only when inside 1..4096.
    function automatic void shadow_write(reg_index_t idx, int data);
        int v;
        v = data & 13'h1fff;
        case (idx)
            REG_FB_WIDTH:
            begin
                fb_w = v;
                area_stale = 1'b1;
            end
            REG_FB_HEIGHT:
            begin
                fb_h = v;
                area_stale = 1'b1;
            end
            REG_WIN_WIDTH:
                if (v >= 1 && v <= 4096)
                begin
                    win_w = v;
                    area_stale = 1'b1;
                end
            REG_WIN_HEIGHT:
                if (v >= 1 && v <= 4096)
                begin
                    win_h = v;
                    area_stale = 1'b1;
                end
            default: ;
        endcase
    endfunction

    // Integer scale 1..3 keeps whole multiples; otherwise fit one axis and
    // keep the aspect ratio. Area is centered.
    function automatic void rebuild_area();
        longint w, h, xs, ys, s, w_for_h;
        int     l, t;
        if (fb_w == 0 || fb_h == 0)
        begin
            w = 0;
            h = 0;
        end
        else
        begin
            xs = win_w / fb_w;
            ys = win_h / fb_h;
            s  = (xs < ys) ? xs : ys;
            if (s < 1 || s >= 4)
            begin
                w_for_h = (longint'(fb_w) * win_h) / fb_h;
                if (w_for_h <= win_w)
                begin
                    w = w_for_h;
                    h = win_h;
                end
                else
                begin
                    w = win_w;
                    h = (longint'(fb_h) * win_w) / fb_w;
                end
            end
            else
            begin
                w = fb_w * s;
                h = fb_h * s;
            end
        end
        area_wd = w[12:0];
        area_ht = h[12:0];
        l = (win_w >> 1) - (area_wd >> 1);
        t = (win_h >> 1) - (area_ht >> 1);
        area_l = l[11:0];
        area_t = t[11:0];
        area_stale = 1'b0;
    endfunction

    // Truncating divide plus offset, saturated to 16 bits.
    function automatic mapped_t scale_axis(longint num, longint den, longint add,
                                           ref logic err);
        longint r;
        if (den == 0)
        begin
            err = 1'b1;
            return (num >= 0) ? 16'sd32767 : -16'sd32768;
        end
        r = num / den + add;
        if (r > 32767)
        begin
            err = 1'b1;
            return 16'sd32767;
        end
        if (r < -32768)
        begin
            err = 1'b1;
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    function automatic mapped_word_t map_point(action_t act, coord_t x, coord_t y);
        mapped_word_t m;
        longint xv, yv;
        xv = x;
        yv = y;
        if (area_stale)
            rebuild_area();
        m.err = 1'b0;
        if (act == 1'b0)
        begin
            m.ox = scale_axis(xv * area_wd, fb_w, area_l, m.err);
            m.oy = scale_axis(yv * area_ht, fb_h, area_t, m.err);
        end
        else
        begin
            m.ox = scale_axis((xv - area_l) * fb_w, area_wd, 0, m.err);
            m.oy = scale_axis((yv - area_t) * fb_h, area_ht, 0, m.err);
        end
        m.ax = area_l;
        m.ay = area_t;
        m.aw = area_wd;
        m.ah = area_ht;
        return m;
    endfunction

    // Result side: random backpressure, compare each word with the oldest expected one.
    always @(posedge clk)
    begin
        mapped_word_t want;
        if (result.valid && result.ready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
                report("unexpected word", 1, 0);
            else
            begin
                want = pending_words.pop_front();
                if (result.out_x !== want.ox) report("out_x", result.out_x, want.ox);
                if (result.out_y !== want.oy) report("out_y", result.out_y, want.oy);
                if (result.area_x !== want.ax) report("area_x", result.area_x, want.ax);
                if (result.area_y !== want.ay) report("area_y", result.area_y, want.ay);
                if (result.area_w !== want.aw) report("area_w", result.area_w, want.aw);
                if (result.area_h !== want.ah) report("area_h", result.area_h, want.ah);
                if (result.error !== want.err) report("error", result.error, want.err);
                if (want.err)
                    sat_seen++;
            end
        end
        result.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Sends one point word; the predictor runs on acceptance so it sees the
    // same register state the block does.
    task automatic send_point(action_t act, coord_t x, coord_t y,
                              bit typed, mapped_word_t ans);
        mapped_word_t m;
        cfg_we <= 1'b0;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            coord.valid <= 1'b0;
            @(posedge clk);
        end
        coord.valid  <= 1'b1;
        coord.action <= act;
        coord.in_x   <= x;
        coord.in_y   <= y;
        do
            @(posedge clk);
        while (!coord.ready);
        m = map_point(act, x, y);
        pending_words.push_back(typed ? ans : m);
        words_sent++;
    endtask

    // Block must be idle before a register write: all words back, pipe empty.
    task automatic drain();
        coord.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the next point word lowers it.
    task automatic write_reg(reg_index_t idx, int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[12:0];
        @(posedge clk);
        shadow_write(idx, data);
    endtask

    function automatic int pick_fb();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(4097, 8191);
            2: return 4096;
            3: return 1;
            4, 5: return $urandom_range(1, 64);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic int pick_win();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(4097, 8191);
            1: return 4096;
            2: return 1;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic coord_t pick_coord();
        int v;
        if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 16383) - 8192;
        else
            v = $urandom_range(0, 4220) - 20;
        return v[13:0];
    endfunction

    dir_row_t dir_tab[22];

    initial
    begin
        int           f, s, k;
        mapped_word_t none;
        bit           prev_cfg;

        none = '{0, 0, 0, 0, 0, 0, 1'b0};
        // Reset leaves 1x1 in 1x1: identity mapping. Zeroed fb sizes divide
        // by zero both ways. 1x1 in 4096x4096 scales by 4096 and saturates.
        // Out-of-range window writes leave the area alone.
        dir_tab = '{
            '{0, REG_FB_WIDTH, 0, 1'b0, 0, 0, 1, '{0, 0, 0, 0, 1, 1, 1'b0}},
            '{0, REG_FB_WIDTH, 0, 1'b0, 8191, -8192, 1,
              '{8191, -8192, 0, 0, 1, 1, 1'b0}},
            '{0, REG_FB_WIDTH, 0, 1'b1, -8192, 8191, 1,
              '{-8192, 8191, 0, 0, 1, 1, 1'b0}},
            '{0, REG_FB_WIDTH, 0, 1'b1, 1, -1, 1, '{1, -1, 0, 0, 1, 1, 1'b0}},
            '{1, REG_FB_WIDTH, 0, 1'b0, 0, 0, 0, none},
            '{1, REG_FB_HEIGHT, 0, 1'b0, 0, 0, 0, none},
            '{0, REG_FB_WIDTH, 0, 1'b0, 5, -5, 1,
              '{32767, 32767, 0, 0, 0, 0, 1'b1}},
            '{0, REG_FB_WIDTH, 0, 1'b1, -8192, 8191, 1,
              '{32767, 32767, 0, 0, 0, 0, 1'b1}},
            '{1, REG_FB_WIDTH, 1, 1'b0, 0, 0, 0, none},
            '{1, REG_FB_HEIGHT, 1, 1'b0, 0, 0, 0, none},
            '{1, REG_WIN_WIDTH, 4096, 1'b0, 0, 0, 0, none},
            '{1, REG_WIN_HEIGHT, 4096, 1'b0, 0, 0, 0, none},
            '{0, REG_FB_WIDTH, 0, 1'b0, 8191, -8192, 1,
              '{32767, -32768, 0, 0, 4096, 4096, 1'b1}},
            '{0, REG_FB_WIDTH, 0, 1'b0, 7, -7, 1,
              '{28672, -28672, 0, 0, 4096, 4096, 1'b0}},
            '{0, REG_FB_WIDTH, 0, 1'b1, 8191, -8192, 1,
              '{1, -2, 0, 0, 4096, 4096, 1'b0}},
            '{1, REG_WIN_WIDTH, 0, 1'b0, 0, 0, 0, none},
            '{1, REG_WIN_HEIGHT, 8191, 1'b0, 0, 0, 0, none},
            '{0, REG_FB_WIDTH, 0, 1'b0, 3, 3, 1,
              '{12288, 12288, 0, 0, 4096, 4096, 1'b0}},
            // very wide framebuffer: area height rounds to zero
            '{1, REG_FB_WIDTH, 8191, 1'b0, 0, 0, 0, none},
            '{0, REG_FB_WIDTH, 0, 1'b0, 8191, 8191, 0, none},
            '{0, REG_FB_WIDTH, 0, 1'b1, 100, -100, 0, none},
            '{0, REG_FB_WIDTH, 0, 1'b1, 3000, 0, 0, none}
        };

        fb_w = 1;
        fb_h = 1;
        win_w = 1;
        win_h = 1;
        area_stale = 1'b1;
        area_l = '0;
        area_t = '0;
        area_wd = '0;
        area_ht = '0;
        mismatches = 0;
        words_sent = 0;
        words_seen = 0;
        sat_seen = 0;
        no_idle = 1'b0;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        coord.valid = 1'b0;
        coord.action = 1'b0;
        coord.in_x = '0;
        coord.in_y = '0;
        result.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        prev_cfg = 1'b0;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                if (!prev_cfg)
                    drain();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
                send_point(dir_tab[i].act, dir_tab[i].x[13:0], dir_tab[i].y[13:0],
                           dir_tab[i].typed, dir_tab[i].ans);
            prev_cfg = dir_tab[i].is_cfg;
        end

        // Random phases: new sizes each phase, then a burst of points.
        // One phase runs with no idling on either side.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            no_idle = (p == 4);
            if ($urandom_range(0, 2) == 0)
            begin
                // aim at the whole-multiple path
                f = $urandom_range(1, 1000);
                s = $urandom_range(1, 3);
                k = f * s + $urandom_range(0, f - 1);
                write_reg(REG_FB_WIDTH, f);
                write_reg(REG_WIN_WIDTH, (k > 4096) ? 4096 : k);
                f = $urandom_range(1, 1000);
                k = f * s + $urandom_range(0, f - 1);
                write_reg(REG_FB_HEIGHT, f);
                write_reg(REG_WIN_HEIGHT, (k > 4096) ? 4096 : k);
            end
            else
            begin
                write_reg(REG_FB_WIDTH, pick_fb());
                write_reg(REG_FB_HEIGHT, pick_fb());
                write_reg(REG_WIN_WIDTH, pick_win());
                write_reg(REG_WIN_HEIGHT, pick_win());
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                send_point(action_t'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                           1'b0, none);
        end

        drain();
        $display("Sent %0d point words over %0d register setups; %0d results checked,",
                 words_sent, PHASES + 4, words_seen);
        $display("%0d of them flagged saturation or a zero divisor.", sat_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/lcm_pkg.sv
hw/rtl/lcm_in_if.sv
hw/rtl/lcm_out_if.sv
hw/rtl/letterbox_coordinate_mapper_top.sv
bench/tb_top.sv
